>>> rtl/rmm_pkg.sv
// Package with the shared constants, codes and transaction types of the running median unit.
`default_nettype none

package rmm_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VALUE_W  = 32;
  localparam int MEDIAN_W = VALUE_W + 1;
  localparam int COUNT_W  = 7;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e                       cmd;
    logic signed [VALUE_W-1:0]  value;
  } in_t;

  typedef struct packed {
    logic signed [MEDIAN_W-1:0] median_doubled;
    logic [COUNT_W-1:0]         entry_count;
    status_e                    status;
  } out_t;

  typedef struct packed {
    logic                       ins;
    logic                       rem;
    logic signed [VALUE_W-1:0]  value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/rmm_cell.sv
// One cell of the sorted chain: holds one value and shifts toward a neighbor on insert or remove.
`default_nettype none

module rmm_cell import rmm_pkg::*; (
  input  wire                        clk_i,
  input  wire cell_ctrl_t            ctrl_i,
  input  wire                        occ_i,
  input  wire                        tail_i,
  input  wire logic signed [VALUE_W-1:0] left_val_i,
  input  wire                        left_gt_i,
  input  wire logic signed [VALUE_W-1:0] right_val_i,
  output logic signed [VALUE_W-1:0]  val_o,
  output logic                       gt_o,
  output logic                       eq_o
);

  logic signed [VALUE_W-1:0] val_q;
  logic signed [VALUE_W-1:0] val_d;

  assign val_o = val_q;
  assign gt_o  = occ_i && (val_q > ctrl_i.value);
  assign eq_o  = occ_i && (val_q == ctrl_i.value);

  always_comb begin
    val_d = val_q;
    if (ctrl_i.ins) begin
      if (left_gt_i) begin
        val_d = left_val_i;
      end else if (gt_o || tail_i) begin
        val_d = ctrl_i.value;
      end
    end else if (ctrl_i.rem) begin
      if (gt_o || eq_o) begin
        val_d = right_val_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

`default_nettype wire

>>> rtl/running_median_multiset_unit.sv
// Top level of the running median unit: a sorted chain of value cells, median pick and output register.
// The chain updates at the accepting edge, the two middle values are then registered in the pick state
// and their sum is loaded into the output register from the sum state, which waits while a result is
// not yet taken; a new input is taken only in the idle state, once the last has left the sum state.
// A new input is taken while a finished result still waits in the output register.
// Reset clears the count, the held median and all control state; cell contents are not reset.
`default_nettype none

module running_median_multiset_unit import rmm_pkg::*; (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire       out_ready_i,
  output out_t      out_data_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PICK,
    S_SUM
  } state_e;

  state_e                     state_q;
  logic [CNT_W-1:0]           count_q;
  status_e                    status_q;
  logic signed [VALUE_W-1:0]  lo_q;
  logic signed [VALUE_W-1:0]  hi_q;
  logic signed [MEDIAN_W-1:0] held_q;
  logic                       out_valid_q;
  out_t                       out_q;

  cell_ctrl_t                 ctrl;
  logic                       accept;
  logic                       full;
  logic                       found;
  logic                       out_load;
  logic [CAPACITY-1:0]        occ;
  logic [CAPACITY-1:0]        tail;
  logic [CAPACITY-1:0]        gt;
  logic [CAPACITY-1:0]        eq;
  logic signed [VALUE_W-1:0]  vals [CAPACITY];
  logic [IDX_W-1:0]           hi_idx;
  logic [IDX_W-1:0]           lo_idx;
  logic signed [VALUE_W-1:0]  lo_sel;
  logic signed [VALUE_W-1:0]  hi_sel;
  logic signed [MEDIAN_W-1:0] sum;
  logic                       order_ok;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign full        = (count_q == CNT_W'(CAPACITY));
  assign found       = |eq;
  assign out_load    = (state_q == S_SUM) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    ctrl.value = in_data_i.value;
    ctrl.ins   = accept && (in_data_i.cmd == CMD_INSERT) && !full;
    ctrl.rem   = accept && (in_data_i.cmd == CMD_REMOVE) && found;
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      occ[i]  = (CNT_W'(i) < count_q);
      tail[i] = (CNT_W'(i) == count_q);
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [VALUE_W-1:0] left_val;
    logic                      left_gt;
    logic signed [VALUE_W-1:0] right_val;

    if (g == 0) begin : g_first
      assign left_val = '0;
      assign left_gt  = 1'b0;
    end else begin : g_inner
      assign left_val = vals[g-1];
      assign left_gt  = gt[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_mid
      assign right_val = vals[g+1];
    end

    rmm_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occ_i       (occ[g]),
      .tail_i      (tail[g]),
      .left_val_i  (left_val),
      .left_gt_i   (left_gt),
      .right_val_i (right_val),
      .val_o       (vals[g]),
      .gt_o        (gt[g]),
      .eq_o        (eq[g])
    );
  end

  assign hi_idx = IDX_W'(count_q >> 1);
  assign lo_idx = count_q[0] ? hi_idx : hi_idx - 1'b1;

  always_comb begin
    lo_sel = '0;
    hi_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (IDX_W'(i) == lo_idx) begin
        lo_sel = lo_sel | vals[i];
      end
      if (IDX_W'(i) == hi_idx) begin
        hi_sel = hi_sel | vals[i];
      end
    end
  end

  assign sum = MEDIAN_W'(lo_q) + MEDIAN_W'(hi_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      status_q    <= ST_DONE;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (in_data_i.cmd == CMD_INSERT) begin
              if (full) begin
                status_q <= ST_FULL;
              end else begin
                status_q <= ST_DONE;
                count_q  <= count_q + 1'b1;
              end
            end else begin
              if (found) begin
                status_q <= ST_DONE;
                count_q  <= count_q - 1'b1;
              end else begin
                status_q <= ST_ABSENT;
              end
            end
            state_q <= S_PICK;
          end
        end
        S_PICK: begin
          state_q <= S_SUM;
        end
        S_SUM: begin
          if (out_load) begin
            if (count_q != '0) begin
              held_q <= sum;
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_PICK) begin
      lo_q <= lo_sel;
      hi_q <= hi_sel;
    end
    if (out_load) begin
      out_q.median_doubled <= (count_q != '0) ? sum : held_q;
      out_q.entry_count    <= COUNT_W'(count_q);
      out_q.status         <= status_q;
    end
  end

  always_comb begin
    order_ok = 1'b1;
    for (int i = 1; i < CAPACITY; i++) begin
      if (occ[i] && (vals[i-1] > vals[i])) begin
        order_ok = 1'b0;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("Held count exceeds the capacity.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_PICK))
    else $error("Accepted transaction did not advance to the pick stage.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_data_i.cmd == CMD_INSERT) && full) |=>
      ((count_q == CNT_W'(CAPACITY)) && (status_q == ST_FULL)))
    else $error("Insert into a full store changed the count or missed the flag.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_data_i.cmd == CMD_REMOVE) && !found) |=>
      ($stable(count_q) && (status_q == ST_ABSENT)))
    else $error("Remove of an absent value changed the count or missed the flag.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PICK) |-> order_ok)
    else $error("Cell chain is not in ascending order.");

endmodule

`default_nettype wire
